// ===== sv/ptw_pkg.sv =====
// ----------------------------------------------------------------------------
// ptw_pkg: shared types and constants of the periodic timer wheel
// Operation and status codes, register indexes and the per-slot record
// that moves along the ring of timer cells.
// ----------------------------------------------------------------------------
`default_nettype none

package ptw_pkg;

  // Field widths
  localparam int IV_W     = 22;
  localparam int STEP_W   = 10;
  localparam int MIN_W    = 6;
  localparam int OP_W     = 2;
  localparam int ID_OUT_W = 4;
  localparam int ST_W     = 2;
  localparam int CFG_IDX_W = 2;

  // Constants of the time base
  localparam int MS_PER_SEC    = 1000;
  localparam int MS_PER_MINUTE = 60000;

  // Default table size
  localparam int MAX_TIMERS_DEF = 16;

  // Operation codes
  localparam logic [OP_W-1:0] OP_TICK = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD  = 2'd1;
  localparam logic [OP_W-1:0] OP_DEL  = 2'd2;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK           = 2'd0;
  localparam logic [ST_W-1:0] ST_BAD_INTERVAL = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL         = 2'd2;
  localparam logic [ST_W-1:0] ST_NOT_FOUND    = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STEP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MINUTES = 2'd1;

  // One timer slot
  typedef struct packed {
    logic            valid;
    logic [IV_W-1:0] period;
    logic [IV_W-1:0] remaining;
  } slot_t;

  // Control of one cell
  typedef struct packed {
    logic shift;
    logic load;
    logic clear;
  } cell_ctl_t;

  // True when the step length is a nonzero divisor of one second
  function automatic logic step_divides_second(logic [STEP_W-1:0] s);
    case (s) inside
      10'd1, 10'd2, 10'd4, 10'd5, 10'd8, 10'd10, 10'd20, 10'd25, 10'd40,
      10'd50, 10'd100, 10'd125, 10'd200, 10'd250, 10'd500, 10'd1000:
        return 1'b1;
      default:
        return 1'b0;
    endcase
  endfunction

endpackage

`default_nettype wire

// ===== sv/ptw_cell.sv =====
// ----------------------------------------------------------------------------
// ptw_cell: one timer slot of the ring
// Holds valid, period and remaining time; takes its neighbor's slot on a
// shift, loads a new timer on an add and frees itself on a delete.
// ----------------------------------------------------------------------------
`default_nettype none

module ptw_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  ptw_pkg::cell_ctl_t        ctl,
  input  ptw_pkg::slot_t            nbr,
  input  logic [ptw_pkg::IV_W-1:0]  load_iv,
  output ptw_pkg::slot_t            slot
);
  import ptw_pkg::*;

  logic            valid;
  logic [IV_W-1:0] period;
  logic [IV_W-1:0] remaining;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.shift) begin
      valid <= nbr.valid;
    end else if (ctl.load) begin
      valid <= 1'b1;
    end else if (ctl.clear) begin
      valid <= 1'b0;
    end
  end

  // Move or load the timer payload
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      period    <= nbr.period;
      remaining <= nbr.remaining;
    end else if (ctl.load) begin
      period    <= load_iv;
      remaining <= load_iv;
    end
  end

  assign slot.valid     = valid;
  assign slot.period    = period;
  assign slot.remaining = remaining;

endmodule

`default_nettype wire

// ===== sv/ptw_rem.sv =====
// ----------------------------------------------------------------------------
// ptw_rem: bit-serial remainder unit
// Restoring division of the interval by the step, one dividend bit per
// cycle; pulses done with the remainder once the last bit is shifted in.
// ----------------------------------------------------------------------------
`default_nettype none

module ptw_rem (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [ptw_pkg::IV_W-1:0]    dividend,
  input  logic [ptw_pkg::STEP_W-1:0]  divisor,
  output logic                        done,
  output logic [ptw_pkg::STEP_W-1:0]  rem
);
  import ptw_pkg::*;

  localparam int CNT_W = $clog2(IV_W + 1);

  logic             busy;
  logic [CNT_W-1:0] count;
  logic [IV_W-1:0]  shreg;
  logic [STEP_W-1:0] dvs;
  logic [STEP_W:0]  trial;
  logic [STEP_W:0]  diff;
  logic             take;

  // Shift in the next dividend bit and try the subtraction
  always_comb begin
    trial = {rem, shreg[IV_W-1]};
    diff  = trial - {1'b0, dvs};
    take  = (trial >= {1'b0, dvs});
  end

  // Sequence the iterations
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        if (count == CNT_W'(IV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        count <= count + 1'b1;
      end
    end
  end

  // Advance the partial remainder
  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      dvs   <= divisor;
      rem   <= '0;
    end else if (busy) begin
      shreg <= {shreg[IV_W-2:0], 1'b0};
      rem   <= take ? diff[STEP_W-1:0] : trial[STEP_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== sv/periodic_timer_wheel_core.sv =====
// ----------------------------------------------------------------------------
// periodic_timer_wheel_core: periodic timer engine over a ring of slots
// Up to MAX_TIMERS periodic timers, advanced one step per tick item.
//
// Input channel (in_valid/in_stall) carries operation, interval_ms and
// target_id; output channel (out_valid/out_stall) carries status, result_id,
// fired and last. Each item yields results ending with one marked last.
// The block takes one item at a time. A tick rotates the ring of cells once,
// one slot per cycle while the output is not stalled, emitting one result
// per fired timer and a closing last result. An add runs the bit-serial
// remainder check, then answers. A delete or an unused code writes its
// result into the output register in the cycle it is taken. The output
// register holds a result until taken; a stalled output halts the ring
// rotation in place. Registers step_ms and wheel_minutes are written through
// cfg_we/cfg_index/cfg_data; the user writes them only while idle, as the
// block has no guard. Reset frees every slot and sets both registers to one.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_timer_wheel_core #(
  parameter int MAX_TIMERS = ptw_pkg::MAX_TIMERS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration
  input  logic                           cfg_we,
  input  logic [ptw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ptw_pkg::STEP_W-1:0]     cfg_data,
  // input items
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [ptw_pkg::OP_W-1:0]       operation,
  input  logic [ptw_pkg::IV_W-1:0]       interval_ms,
  input  logic [ptw_pkg::ID_OUT_W-1:0]   target_id,
  // result items
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ptw_pkg::ST_W-1:0]       status,
  output logic [ptw_pkg::ID_OUT_W-1:0]   result_id,
  output logic                           fired,
  output logic                           last
);
  import ptw_pkg::*;

  localparam int ID_W = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TICK = 3'd1;
  localparam logic [2:0] S_TEND = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_ADDF = 3'd4;

  logic [2:0]        state;
  logic [2:0]        state_next;
  logic [ID_W-1:0]   cnt;
  logic [STEP_W-1:0] step_ms;
  logic [MIN_W-1:0]  wheel_minutes;
  logic [IV_W-1:0]   add_iv;
  logic [IV_W-1:0]   limit;

  slot_t     slots [MAX_TIMERS];
  cell_ctl_t ctls  [MAX_TIMERS];
  slot_t     head_next;
  logic      head_fire;

  logic              out_free;
  logic              accept;
  logic              shift;
  logic              div_done;
  logic [STEP_W-1:0] div_rem;
  logic              add_ok;
  logic              free_any;
  logic [ID_W-1:0]   free_idx;
  logic              del_hit;
  logic [ID_W-1:0]   del_idx;
  logic [ID_W+ID_OUT_W-1:0] del_wide;
  logic [ID_W+ID_OUT_W-1:0] cnt_wide;
  logic [ID_W+ID_OUT_W-1:0] free_wide;
  logic              do_load;
  logic              do_clear;

  logic              emit;
  logic [ST_W-1:0]   emit_status;
  logic [ID_OUT_W-1:0] emit_id;
  logic              emit_fired;
  logic              emit_last;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      step_ms       <= STEP_W'(1);
      wheel_minutes <= MIN_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STEP:    step_ms       <= cfg_data;
        REG_MINUTES: wheel_minutes <= cfg_data[MIN_W-1:0];
        default:     ;
      endcase
    end
  end

  assign out_free = !out_valid || !out_stall;
  assign in_stall = !((state == S_IDLE) && out_free);
  assign accept   = in_valid && !in_stall;
  assign shift    = (state == S_TICK) && out_free;

  // Process the slot leaving the head of the ring
  always_comb begin
    head_next = slots[0];
    head_fire = slots[0].valid && (slots[0].remaining <= IV_W'(step_ms));
    if (head_fire) begin
      head_next.remaining = slots[0].period;
    end else if (slots[0].valid) begin
      head_next.remaining = slots[0].remaining - IV_W'(step_ms);
    end
  end

  // Find the lowest free slot
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int k = MAX_TIMERS - 1; k >= 0; k--) begin
      if (!slots[k].valid) begin
        free_any = 1'b1;
        free_idx = ID_W'(k);
      end
    end
  end

  // Decode the delete target
  always_comb begin
    del_wide = {{ID_W{1'b0}}, target_id};
    del_idx  = del_wide[ID_W-1:0];
    del_hit  = (32'(target_id) < 32'(MAX_TIMERS)) && slots[del_idx].valid;
  end

  // Validate the add interval
  always_comb begin
    add_ok = step_divides_second(step_ms) && (add_iv >= IV_W'(step_ms)) &&
             (div_rem == '0) && (add_iv < limit);
  end

  assign do_load  = (state == S_ADDF) && out_free && add_ok && free_any;
  assign do_clear = accept && (operation == OP_DEL) && del_hit;

  // Ring of cells
  for (genvar k = 0; k < MAX_TIMERS; k++) begin : g_cell
    slot_t nbr;
    if (k == MAX_TIMERS - 1) begin : g_tail
      assign nbr = head_next;
    end else begin : g_mid
      assign nbr = slots[k+1];
    end
    assign ctls[k].shift = shift;
    assign ctls[k].load  = do_load && (free_idx == ID_W'(k));
    assign ctls[k].clear = do_clear && (del_idx == ID_W'(k));
    ptw_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctls[k]),
      .nbr     (nbr),
      .load_iv (add_iv),
      .slot    (slots[k])
    );
  end

  // Remainder check of the interval against the step
  ptw_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (accept && (operation == OP_ADD)),
    .dividend (interval_ms),
    .divisor  (step_ms),
    .done     (div_done),
    .rem      (div_rem)
  );

  // Hold the add operands
  always_ff @(posedge clk) begin
    if (accept) begin
      add_iv <= interval_ms;
      limit  <= IV_W'(MS_PER_MINUTE) * IV_W'(wheel_minutes);
    end
  end

  assign cnt_wide  = {{ID_OUT_W{1'b0}}, cnt};
  assign free_wide = {{ID_OUT_W{1'b0}}, free_idx};

  // Sequencer and result selection
  always_comb begin
    state_next  = state;
    emit        = 1'b0;
    emit_status = ST_OK;
    emit_id     = '0;
    emit_fired  = 1'b0;
    emit_last   = 1'b1;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (operation)
            OP_TICK: state_next = S_TICK;
            OP_ADD:  state_next = S_DIV;
            OP_DEL: begin
              emit        = 1'b1;
              emit_status = del_hit ? ST_OK : ST_NOT_FOUND;
            end
            default: emit = 1'b1;
          endcase
        end
      end
      S_TICK: begin
        if (shift) begin
          emit       = head_fire;
          emit_id    = cnt_wide[ID_OUT_W-1:0];
          emit_fired = 1'b1;
          emit_last  = 1'b0;
          if (cnt == ID_W'(MAX_TIMERS - 1)) begin
            state_next = S_TEND;
          end
        end
      end
      S_TEND: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_ADDF;
        end
      end
      S_ADDF: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = S_IDLE;
          if (!add_ok) begin
            emit_status = ST_BAD_INTERVAL;
          end else if (!free_any) begin
            emit_status = ST_FULL;
          end else begin
            emit_id = free_wide[ID_OUT_W-1:0];
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State and slot counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        cnt <= '0;
      end else if (shift) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && emit) begin
      status    <= emit_status;
      result_id <= emit_id;
      fired     <= emit_fired;
      last      <= emit_last;
    end
  end

  // Checks
  a_busy_stalls: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall)
    else $error("input taken while an item is in progress");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_TICK) |-> (32'(cnt) < 32'(MAX_TIMERS)))
    else $error("ring counter beyond table");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("remainder result outside add check");

  a_fire_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && fired) |-> ((status == ST_OK) && !last))
    else $error("expiry result malformed");

  a_load_once: assert property (@(posedge clk) disable iff (rst)
    do_load |=> (state == S_IDLE))
    else $error("add did not finish after slot load");

endmodule

`default_nettype wire
